// File: hdl/qph_pkg.sv
// Shared constants and state codes for the quadratic probe hash insert core.
package qph_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int SIZE_W     = SLOT_W + 1;
  localparam int KEY_W      = 16;
  localparam int HASH_W     = 32;
  localparam int COLL_W     = 16;
  localparam int MOD_DIGIT  = 4;
  localparam int MOD_STEPS  = HASH_W / MOD_DIGIT;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);
  localparam int SIZE_RESET = 31;

  localparam logic [COLL_W-1:0] COLL_MAX = '1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;

  typedef logic [KEY_W:0] entry_t;

endpackage

// File: hdl/quadratic_probe_hash_insert_core.sv
// Top level: open-addressing hash insert with quadratic probing over one slot memory.
//
// Usage: raise start with cmd, key_hash and key_handle while busy is low; the
// beat is taken at that edge. cmd insert places key_handle in the first free
// slot of home, home+1, home+4, home+9 ... (mod table size), home being
// key_hash mod table size. cmd clear empties the table and zeroes counters.
// Each command yields one result beat: done is high for exactly one cycle
// with slot, probes_used, collision_total, entry_total, load_exceeded and
// insert_failed valid in that cycle. The receiver cannot stall; results
// hold their value until the next beat but are only marked once.
// An insert takes the beat, forms the remainder (4 hash bits per cycle
// through one restoring divider step, reused for each digit), then runs
// each probe as one memory read followed by one check. A clear sweeps all
// 1024 memory entries, one per cycle, and reports at the end. One item is
// in flight at a time; the next beat may be taken in the cycle that done
// is high. Reset runs the same clearing pass with busy high and no result
// beat; table_size returns to 31. The user must write table_size through
// cfg_wr_en / cfg_wr_data only while busy is low; the block itself does
// not enforce this. 0 acts as 1 and values above 1024 act as 1024.
module quadratic_probe_hash_insert_core
  import qph_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  logic [HASH_W-1:0] key_hash,
  input  logic [KEY_W-1:0]  key_handle,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  output logic              done,
  output logic [SLOT_W-1:0] slot,
  output logic [SIZE_W-1:0] probes_used,
  output logic [COLL_W-1:0] collision_total,
  output logic [SIZE_W-1:0] entry_total,
  output logic              load_exceeded,
  output logic              insert_failed
);

  // Control and working registers, with their combinational next values
  logic [2:0]           state;
  logic [SIZE_W-1:0]    table_size;
  logic [SIZE_W-1:0]    eff_size;
  logic [SLOT_W-1:0]    clr_idx;
  logic                 clr_report;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [HASH_W-1:0]    hash_sr;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    rem_next;
  logic [SLOT_W-1:0]    pos;
  logic [SLOT_W-1:0]    pos_next;
  logic [SLOT_W-1:0]    delta;
  logic [SLOT_W-1:0]    delta_next;
  logic [SIZE_W-1:0]    probe_k;
  logic [SIZE_W-1:0]    probe_k_inc;
  logic [KEY_W-1:0]     handle_q;
  logic [COLL_W-1:0]    coll_count;
  logic [SIZE_W-1:0]    entry_count;
  logic [COLL_W:0]      coll_sum;
  logic [COLL_W-1:0]    coll_sat;
  logic [SIZE_W-1:0]    entry_inc;
  logic [SIZE_W:0]      pos_sum;
  logic [SIZE_W:0]      delta_sum;

  // Slot memory: {used, key}, one write port, one registered read port
  entry_t               tbl_mem [MAX_SLOTS];
  entry_t               rd_data;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  entry_t               mem_wdata;

  assign busy = (state != ST_IDLE);

  // Clamp the configured size into 1 .. MAX_SLOTS
  always_comb begin
    if (table_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (table_size > SIZE_W'(MAX_SLOTS)) begin
      eff_size = SIZE_W'(MAX_SLOTS);
    end else begin
      eff_size = table_size;
    end
  end

  // Remainder step: fold in MOD_DIGIT hash bits, one conditional subtract each
  always_comb begin
    logic [SIZE_W:0] acc;
    acc = {1'b0, rem};
    for (int i = 0; i < MOD_DIGIT; i++) begin
      acc = {acc[SIZE_W-1:0], hash_sr[HASH_W-1-i]};
      if (acc >= {1'b0, eff_size}) begin
        acc = acc - {1'b0, eff_size};
      end
    end
    rem_next = acc[SIZE_W-1:0];
  end

  // Next probe position: pos + (2k+1), then the odd step grows by two, both mod size
  always_comb begin
    pos_sum   = {2'b00, pos} + {2'b00, delta};
    delta_sum = {2'b00, delta} + (SIZE_W+1)'(2);
    if (pos_sum >= {1'b0, eff_size}) begin
      pos_next = SLOT_W'(pos_sum - {1'b0, eff_size});
    end else begin
      pos_next = pos_sum[SLOT_W-1:0];
    end
    if (eff_size == SIZE_W'(1)) begin
      delta_next = '0;
    end else if (delta_sum >= {1'b0, eff_size}) begin
      delta_next = SLOT_W'(delta_sum - {1'b0, eff_size});
    end else begin
      delta_next = delta_sum[SLOT_W-1:0];
    end
  end

  assign probe_k_inc = probe_k + SIZE_W'(1);
  assign entry_inc   = entry_count + SIZE_W'(1);

  // Saturating collision total after adding this insert's occupied slots
  always_comb begin
    coll_sum = {1'b0, coll_count} + (COLL_W+1)'(probe_k);
    if (!rd_data[KEY_W]) begin
      coll_sum = {1'b0, coll_count} + (COLL_W+1)'(probe_k);
    end else begin
      coll_sum = {1'b0, coll_count} + (COLL_W+1)'(probe_k_inc);
    end
    coll_sat = coll_sum[COLL_W] ? COLL_MAX : coll_sum[COLL_W-1:0];
  end

  // Memory write select: sweep clears, a free slot takes the key
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {1'b1, handle_q};
    case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_CHECK: begin
        mem_we = !rd_data[KEY_W];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= tbl_mem[pos];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_W'(SIZE_RESET);
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      clr_idx     <= '0;
      clr_report  <= 1'b0;
      done        <= 1'b0;
      coll_count  <= '0;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_SWEEP: begin
          clr_idx <= clr_idx + SLOT_W'(1);
          if (clr_idx == SLOT_W'(MAX_SLOTS - 1)) begin
            state <= ST_IDLE;
            if (clr_report) begin
              done            <= 1'b1;
              slot            <= '0;
              probes_used     <= '0;
              collision_total <= '0;
              entry_total     <= '0;
              load_exceeded   <= 1'b0;
              insert_failed   <= 1'b0;
            end
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (cmd == CMD_CLEAR) begin
              // Drop counters now, sweep the memory, report at the end
              state       <= ST_SWEEP;
              clr_idx     <= '0;
              clr_report  <= 1'b1;
              coll_count  <= '0;
              entry_count <= '0;
            end else begin
              state    <= ST_MOD;
              hash_sr  <= key_hash;
              handle_q <= key_handle;
              rem      <= '0;
              mod_cnt  <= '0;
            end
          end
        end
        ST_MOD: begin
          rem     <= rem_next;
          hash_sr <= hash_sr << MOD_DIGIT;
          mod_cnt <= mod_cnt + MOD_CNT_W'(1);
          if (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
            state   <= ST_READ;
            pos     <= rem_next[SLOT_W-1:0];
            delta   <= (eff_size == SIZE_W'(1)) ? SLOT_W'(0) : SLOT_W'(1);
            probe_k <= '0;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!rd_data[KEY_W]) begin
            // Free slot: key written this cycle, report success
            state           <= ST_IDLE;
            coll_count      <= coll_sat;
            entry_count     <= entry_inc;
            done            <= 1'b1;
            slot            <= pos;
            probes_used     <= probe_k;
            collision_total <= coll_sat;
            entry_total     <= entry_inc;
            load_exceeded   <= ({entry_inc, 1'b0} > {1'b0, eff_size});
            insert_failed   <= 1'b0;
          end else if (probe_k_inc == eff_size) begin
            // Every reachable position tried: fail without inserting
            state           <= ST_IDLE;
            coll_count      <= coll_sat;
            done            <= 1'b1;
            slot            <= '0;
            probes_used     <= probe_k_inc;
            collision_total <= coll_sat;
            entry_total     <= entry_count;
            load_exceeded   <= ({entry_count, 1'b0} > {1'b0, eff_size});
            insert_failed   <= 1'b1;
          end else begin
            // Occupied: advance along the quadratic sequence
            state   <= ST_READ;
            probe_k <= probe_k_inc;
            pos     <= pos_next;
            delta   <= delta_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
